// ----- hdl/sbmq_pkg.sv -----
// shared constants and codes for the shared buffer multi queue
`default_nettype none

package sbmq_pkg;

  // default sizing
  localparam int ENTRIES_DEF = 16;
  localparam int QUEUES_DEF  = 4;

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int QID_W    = 2;
  localparam int STATUS_W = 2;

  // operation kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/shared_buffer_multi_queue_top.sv -----
// several fifo queues sharing one linked entry store with a free list
//
//   channel | direction | handshake            | words
//   req     | in        | req_valid, req_stall | kind, queue_id, data_in
//   rsp     | out       | rsp_valid, rsp_stall | data_out, status
//
// a good enqueue runs look, link, out; a good dequeue look, free, out; a
// rejected word look, out. a new word is taken only when idle or as a result
// enters the output register. the steps are set by the single link memory
// port: an enqueue writes up to two links, a dequeue reads the head pointer
// before it can read its link. reset is synchronous; the link memory needs
// no clearing pass, a fill count stands in for its initial chain. a stalled
// result holds in the output register while the next word is already taken in.
`default_nettype none

module shared_buffer_multi_queue_top #(
  parameter int ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int QUEUES  = sbmq_pkg::QUEUES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic                                kind,
  input  wire logic [sbmq_pkg::QID_W-1:0]          queue_id,
  input  wire logic signed [sbmq_pkg::DATA_W-1:0]  data_in,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic signed [sbmq_pkg::DATA_W-1:0]       data_out,
  output logic [sbmq_pkg::STATUS_W-1:0]            status
);

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int DW = sbmq_pkg::DATA_W;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // memories
  logic [PW-1:0]   links [ENTRIES];
  logic [DW-1:0]   values [ENTRIES];
  logic [2*PW-1:0] qptrs [QUEUES];
  logic [QUEUES-1:0] qvalid;

  // control and working registers
  logic [2:0]      state;
  logic            kind_r;
  logic            qok_r;
  logic [QW-1:0]   q_r;
  logic [DW-1:0]   data_r;
  logic [PW-1:0]   free_head;
  logic [PW-1:0]   fill;
  logic [PW-1:0]   slot_r;
  logic [PW-1:0]   tail_keep;
  logic            qhit_r;
  logic [2*PW-1:0] qrd;
  logic [PW-1:0]   lnk_rdata;
  logic [PW-1:0]   lnk_raddr;
  logic [DW-1:0]   val_rdata;
  logic [DW-1:0]   res_data;
  logic [sbmq_pkg::STATUS_W-1:0] res_status;

  // combinational helpers
  logic            out_free;
  logic            accept;
  logic [QW-1:0]   qidx;
  logic            q_ok;
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [PW-1:0]   link_val;
  logic            lnk_re;
  logic [PW-1:0]   lnk_ra;
  logic            lnk_we;
  logic [PW-1:0]   lnk_wa;
  logic [PW-1:0]   lnk_wd;
  logic            q_we;
  logic [2*PW-1:0] q_wd;
  logic            enq_full;
  logic            deq_empty;

  // handshake
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) || (state == S_OUT && out_free));
  assign accept    = req_valid && !req_stall;
  assign qidx      = QW'(queue_id);
  assign q_ok      = 32'(queue_id) < QUEUES;

  // queue pointers seen in the lookup cycle
  assign head = qhit_r ? qrd[2*PW-1:PW] : NIL;
  assign tail = qhit_r ? qrd[PW-1:0] : NIL;

  // link of the slot read last; slots at or past the fill count read as i+1
  always_comb begin
    if (lnk_raddr >= NIL) begin
      link_val = NIL;
    end else if (lnk_raddr >= fill) begin
      link_val = lnk_raddr + PW'(1);
    end else if (lnk_rdata >= NIL) begin
      link_val = NIL;
    end else begin
      link_val = lnk_rdata;
    end
  end

  assign enq_full  = !qok_r || (free_head >= NIL);
  assign deq_empty = !qok_r || (head >= NIL);

  // link memory port control
  always_comb begin
    lnk_re = 1'b0;
    lnk_ra = free_head;
    lnk_we = 1'b0;
    lnk_wa = slot_r;
    lnk_wd = NIL;
    q_we   = 1'b0;
    q_wd   = {head, tail_keep};
    unique case (state)
      S_LOOK: begin
        if (kind_r == sbmq_pkg::KIND_DEQ) begin
          lnk_re = !deq_empty;
          lnk_ra = head;
        end else if (!enq_full) begin
          lnk_we = (head < NIL) && (tail < NIL);
          lnk_wa = tail;
          lnk_wd = free_head;
          q_we   = 1'b1;
          q_wd   = {((head < NIL) ? head : free_head), free_head};
        end
      end
      S_LINK: begin
        lnk_we = 1'b1;
        lnk_wa = slot_r;
        lnk_wd = NIL;
      end
      S_FREE: begin
        lnk_we = 1'b1;
        lnk_wa = slot_r;
        lnk_wd = free_head;
        q_we   = 1'b1;
        q_wd   = {link_val, tail_keep};
      end
      default: begin
        lnk_re = accept && (kind == sbmq_pkg::KIND_ENQ);
        lnk_ra = free_head;
      end
    endcase
  end

  // link memory
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      links[lnk_wa[IW-1:0]] <= lnk_wd;
    end
    if (lnk_re) begin
      lnk_rdata <= links[lnk_ra[IW-1:0]];
      lnk_raddr <= lnk_ra;
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (state == S_LOOK && kind_r == sbmq_pkg::KIND_ENQ && !enq_full) begin
      values[free_head[IW-1:0]] <= data_r;
    end
    if (state == S_LOOK && kind_r == sbmq_pkg::KIND_DEQ) begin
      val_rdata <= values[head[IW-1:0]];
    end
  end

  // queue pointer memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      qptrs[q_r] <= q_wd;
    end
    if (accept) begin
      qrd <= qptrs[qidx];
    end
  end

  // sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      fill      <= '0;
      qvalid    <= '0;
    end else begin
      unique case (state)
        S_LOOK: begin
          if (kind_r == sbmq_pkg::KIND_ENQ) begin
            if (enq_full) begin
              state <= S_OUT;
            end else begin
              free_head <= link_val;
              if (free_head == fill) begin
                fill <= fill + PW'(1);
              end
              qvalid[q_r] <= 1'b1;
              state <= S_LINK;
            end
          end else begin
            state <= deq_empty ? S_OUT : S_FREE;
          end
        end
        S_LINK: begin
          state <= S_OUT;
        end
        S_FREE: begin
          free_head <= slot_r;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= accept ? S_LOOK : S_IDLE;
          end
        end
        default: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
      endcase
    end
  end

  // working registers for the word in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      qok_r  <= q_ok;
      q_r    <= qidx;
      data_r <= data_in;
      qhit_r <= q_ok && qvalid[qidx];
    end
    if (state == S_LOOK) begin
      slot_r    <= (kind_r == sbmq_pkg::KIND_ENQ) ? free_head : head;
      tail_keep <= tail;
      res_data  <= '0;
      if (kind_r == sbmq_pkg::KIND_ENQ) begin
        res_status <= enq_full ? sbmq_pkg::ST_FULL : sbmq_pkg::ST_OK;
      end else begin
        res_status <= deq_empty ? sbmq_pkg::ST_EMPTY : sbmq_pkg::ST_OK;
      end
    end
    if (state == S_FREE) begin
      res_data <= val_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      data_out <= res_data;
      status   <= res_status;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sbmq_check.sv -----
// port level checker for the shared buffer multi queue, bound to the top level
`default_nettype none

module sbmq_check (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_stall,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_stall,
  input wire logic [sbmq_pkg::DATA_W-1:0]        data_out,
  input wire logic [sbmq_pkg::STATUS_W-1:0]      status
);

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(data_out) && $stable(status))
    else $error("stalled result word changed");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == sbmq_pkg::ST_OK || status == sbmq_pkg::ST_FULL ||
                   status == sbmq_pkg::ST_EMPTY))
    else $error("undefined status code");

  // rejected words carry zero data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != sbmq_pkg::ST_OK |-> data_out == '0)
    else $error("error result with nonzero data");

  // one word in flight: the cycle after an accept is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second word taken while one is in flight");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind shared_buffer_multi_queue_top sbmq_check u_sbmq_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .data_out  (data_out),
  .status    (status)
);

`default_nettype wire

// ----- sim/sbmq_checker.sv -----
// checker for the shared buffer multi queue: watches both channels, predicts and compares
`timescale 1ns / 100ps

module sbmq_checker #(
  parameter int ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int QUEUES  = sbmq_pkg::QUEUES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  logic                                kind,
  input  logic [sbmq_pkg::QID_W-1:0]          queue_id,
  input  logic signed [sbmq_pkg::DATA_W-1:0]  data_in,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  logic signed [sbmq_pkg::DATA_W-1:0]  data_out,
  input  logic [sbmq_pkg::STATUS_W-1:0]       status,
  output int                                  fail_cnt,
  output int                                  pend_cnt
);

  // one expected result word
  typedef struct {
    logic signed [sbmq_pkg::DATA_W-1:0] data;
    logic [sbmq_pkg::STATUS_W-1:0]      status;
  } rsp_word_t;

  // null pointer is one past the last slot
  localparam int NIL = ENTRIES;

  // shadow copy of the entry store and its lists
  logic signed [sbmq_pkg::DATA_W-1:0] slot_value [ENTRIES];
  int                                 slot_next  [ENTRIES];
  int                                 head_of    [QUEUES];
  int                                 tail_of    [QUEUES];
  int                                 free_top;

  rsp_word_t rsp_expected [$];
  int        errs = 0;

  // store and lists back to their power-up shape
  function automatic void clear_lists();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = i + 1;
    end
    for (int i = 0; i < QUEUES; i++) begin
      head_of[i] = NIL;
      tail_of[i] = NIL;
    end
    free_top = 0;
  endfunction

  // apply one accepted word to the shadow lists and return its result
  function automatic rsp_word_t predict_rsp(logic k, logic [sbmq_pkg::QID_W-1:0] q,
                                            logic signed [sbmq_pkg::DATA_W-1:0] d);
    rsp_word_t r;
    int        slot;
    r.data   = '0;
    r.status = sbmq_pkg::ST_OK;
    if (k == sbmq_pkg::KIND_ENQ) begin
      if (int'(q) >= QUEUES || free_top >= ENTRIES) begin
        r.status = sbmq_pkg::ST_FULL;
      end else begin
        slot     = free_top;
        free_top = (slot_next[slot] < ENTRIES) ? slot_next[slot] : NIL;
        // empty queue (stale tail ignored) gets a fresh head
        if (head_of[q] >= ENTRIES) begin
          head_of[q] = slot;
        end else if (tail_of[q] < ENTRIES) begin
          slot_next[tail_of[q]] = slot;
        end
        slot_next[slot]  = NIL;
        tail_of[q]       = slot;
        slot_value[slot] = d;
      end
    end else begin
      if (int'(q) >= QUEUES || head_of[q] >= ENTRIES) begin
        r.status = sbmq_pkg::ST_EMPTY;
      end else begin
        slot            = head_of[q];
        head_of[q]      = (slot_next[slot] < ENTRIES) ? slot_next[slot] : NIL;
        slot_next[slot] = free_top;
        free_top        = slot;
        r.data          = slot_value[slot];
      end
    end
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin : watch
    rsp_word_t want;
    if (rst) begin
      clear_lists();
      rsp_expected.delete();
    end else begin
      if (req_valid && !req_stall) begin
        rsp_expected.push_back(predict_rsp(kind, queue_id, data_in));
      end
      if (rsp_valid && !rsp_stall) begin
        if (rsp_expected.size() == 0) begin
          errs++;
          $error("unexpected result word: data_out %0d status %0d", data_out, status);
        end else begin
          want = rsp_expected.pop_front();
          if (data_out !== want.data) begin
            errs++;
            $error("data_out mismatch: expected %0d, got %0d", want.data, data_out);
          end
          if (status !== want.status) begin
            errs++;
            $error("status mismatch: expected %0d, got %0d", want.status, status);
          end
        end
      end
    end
    fail_cnt <= errs;
    pend_cnt <= rsp_expected.size();
  end

endmodule

// ----- sim/shared_buffer_multi_queue_top_tb.sv -----
// testbench top for the shared buffer multi queue: stimulus, idling and verdict
`timescale 1ns / 100ps

module shared_buffer_multi_queue_top_tb;

  localparam int ENTRIES = 16;
  localparam int QUEUES  = 4;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                req_valid = 1'b0;
  logic                                req_stall;
  logic                                kind = sbmq_pkg::KIND_ENQ;
  logic [sbmq_pkg::QID_W-1:0]          queue_id = '0;
  logic signed [sbmq_pkg::DATA_W-1:0]  data_in = '0;
  logic                                rsp_valid;
  logic                                rsp_stall = 1'b1;
  logic signed [sbmq_pkg::DATA_W-1:0]  data_out;
  logic [sbmq_pkg::STATUS_W-1:0]       status;

  int fail_cnt;
  int pend_cnt;

  // idling switches, changed per block of words
  bit send_gaps = 1'b1;
  bit rsp_lazy  = 1'b1;

  always #4 clk = ~clk;

  shared_buffer_multi_queue_top #(
    .ENTRIES(ENTRIES),
    .QUEUES (QUEUES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .kind     (kind),
    .queue_id (queue_id),
    .data_in  (data_in),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .data_out (data_out),
    .status   (status)
  );

  sbmq_checker #(
    .ENTRIES(ENTRIES),
    .QUEUES (QUEUES)
  ) chk (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .kind     (kind),
    .queue_id (queue_id),
    .data_in  (data_in),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .data_out (data_out),
    .status   (status),
    .fail_cnt (fail_cnt),
    .pend_cnt (pend_cnt)
  );

  // present one word after an optional gap, return at the edge that takes it
  task automatic send_word(input logic k, input logic [sbmq_pkg::QID_W-1:0] q,
                           input logic signed [sbmq_pkg::DATA_W-1:0] d);
    int gap;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    queue_id  <= q;
    data_in   <= d;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // drop valid and hold off until every result is back
  task automatic drain_queues();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pend_cnt != 0) @(posedge clk);
  endtask

  // value mix: mostly random, sometimes an extreme
  function automatic logic signed [sbmq_pkg::DATA_W-1:0] pick_data();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // result side: random stall before each word, bursts with none
  initial begin : rsp_side
    int hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = rsp_lazy ? $urandom_range(0, 18) : 0;
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stim
    int                         enq_pct;
    int                         hot_q;
    bit                         use_hot;
    logic                       k;
    logic [sbmq_pkg::QID_W-1:0] q;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: empty queue, extremes, last entry out, refill, full store
    send_word(sbmq_pkg::KIND_DEQ, 2'd0, 32'sd5);
    send_word(sbmq_pkg::KIND_ENQ, 2'd0, 32'sh8000_0000);
    send_word(sbmq_pkg::KIND_ENQ, 2'd1, 32'sh7fff_ffff);
    send_word(sbmq_pkg::KIND_ENQ, 2'd2, 32'sd0);
    send_word(sbmq_pkg::KIND_ENQ, 2'd3, -32'sd1);
    send_word(sbmq_pkg::KIND_DEQ, 2'd3, 32'sh7fff_ffff);
    send_word(sbmq_pkg::KIND_DEQ, 2'd3, 32'sd0);
    send_word(sbmq_pkg::KIND_ENQ, 2'd3, 32'sh5555_5555);
    send_word(sbmq_pkg::KIND_ENQ, 2'd3, 32'shaaaa_aaaa);
    for (int i = 0; i < ENTRIES - 5; i++) begin
      send_word(sbmq_pkg::KIND_ENQ, sbmq_pkg::QID_W'(i), $urandom);
    end
    send_word(sbmq_pkg::KIND_ENQ, 2'd1, 32'sh1234_5678);
    send_word(sbmq_pkg::KIND_DEQ, 2'd2, -32'sd1);
    send_word(sbmq_pkg::KIND_ENQ, 2'd2, 32'sh0f0f_0f0f);

    // random blocks with varying enqueue bias, hot queue and idling
    for (int blk = 0; blk < 17; blk++) begin
      case ($urandom_range(0, 3))
        0:       enq_pct = 20;
        1:       enq_pct = 50;
        2:       enq_pct = 80;
        default: enq_pct = $urandom_range(0, 100);
      endcase
      hot_q     = $urandom_range(0, QUEUES - 1);
      use_hot   = 1'($urandom_range(0, 1));
      send_gaps = 1'($urandom_range(0, 1));
      rsp_lazy  = 1'($urandom_range(0, 1));
      if (blk == 8) drain_queues();
      for (int i = 0; i < 50; i++) begin
        k = ($urandom_range(0, 99) < enq_pct) ? sbmq_pkg::KIND_ENQ : sbmq_pkg::KIND_DEQ;
        q = (use_hot && $urandom_range(0, 3) != 0) ? sbmq_pkg::QID_W'(hot_q)
                                                     : sbmq_pkg::QID_W'($urandom);
        send_word(k, q, pick_data());
      end
    end

    drain_queues();
    repeat (16) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
